FILE: hw/rtl/vibe_background_subtractor_defines.svh
// Assertion macros for the background subtractor.
`ifndef VIBE_BACKGROUND_SUBTRACTOR_DEFINES_SVH
`define VIBE_BACKGROUND_SUBTRACTOR_DEFINES_SVH
`ifndef SYNTH
// Check under reset disable.
`define VBS_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
// Check that also holds during reset.
`define VBS_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) (expr)) else $error("assertion failed");
`else
`define VBS_ASSERT(name, expr)
`define VBS_ASSERT_ALWAYS(name, expr)
`endif
`endif

FILE: hw/rtl/vibe_bs_pkg.sv
// Shared types, constants and helpers for the background subtractor.
package vibe_bs_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int SAMPLES_DEF    = 20;

	localparam logic [4:0]  MIN_MATCHES_RST   = 5'd2;
	localparam logic [7:0]  MATCH_RADIUS_RST  = 8'd20;
	localparam logic [7:0]  UPDATE_FACTOR_RST = 8'd16;
	localparam logic [7:0]  STALE_LIMIT_RST   = 8'd15;
	localparam logic [7:0]  FRAME_WIDTH_RST   = 8'd128;
	localparam logic [7:0]  FRAME_HEIGHT_RST  = 8'd128;
	localparam logic [31:0] RANDOM_SEED_RST   = 32'd1;

	localparam logic [7:0] WINDOW_DRAW_N = 8'd9;
	localparam int WIN_CENTER = 4;

	typedef enum logic [2:0] {
		CFG_MIN_MATCHES   = 3'd0,
		CFG_MATCH_RADIUS  = 3'd1,
		CFG_UPDATE_FACTOR = 3'd2,
		CFG_STALE_LIMIT   = 3'd3,
		CFG_FRAME_WIDTH   = 3'd4,
		CFG_FRAME_HEIGHT  = 3'd5,
		CFG_RANDOM_SEED   = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_LOAD, ST_INIT_R, ST_INIT_C, ST_MATCH, ST_COUNT,
		ST_BG_U1, ST_BG_S1, ST_BG_U2, ST_BG_NR, ST_BG_NC, ST_BG_S2,
		ST_FG_P, ST_FG_S, ST_WR_OWN, ST_NB_RD, ST_NB_LOAD, ST_NB_WR, ST_DONE
	} state_t;

	// Map a draw of 9 to an offset code: 0, 1, 2 stand for -1, 0, +1.
	function automatic logic [1:0] off_code(input logic [3:0] idx);
		logic [1:0] r;
		case (idx)
			4'd0: r = 2'd0;
			4'd1: r = 2'd1;
			4'd2: r = 2'd2;
			4'd3: r = 2'd0;
			4'd4: r = 2'd2;
			4'd5: r = 2'd0;
			4'd6: r = 2'd1;
			4'd7: r = 2'd2;
			4'd8: r = 2'd1;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	// One xorshift advance, shifts 13, 17, 5.
	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] a;
		logic [31:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

FILE: hw/rtl/vibe_background_subtractor.sv
// Top level of the gray-pixel background subtractor.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  pixel in  | start & !busy      | action, pix_row, pix_col, nine window values
//  result    | done (one cycle)   | foreground, stale_count
//  config    | cfg_we             | cfg_index, cfg_data
//
// After reset the block sweeps both memories to zero, one pixel per cycle, with
// busy high; config writes are taken meanwhile.
// An initialise transaction makes two random draws per sample, row then column.
// A test transaction shares the single memory port and makes at most one draw per
// cycle. Outside pixels go straight to done, border pixels right after the read.
// The result strobe lasts one cycle and cannot be held off.
`include "vibe_background_subtractor_defines.svh"

module vibe_background_subtractor #(
	parameter int MAX_WIDTH  = vibe_bs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = vibe_bs_pkg::MAX_HEIGHT_DEF,
	parameter int SAMPLES    = vibe_bs_pkg::SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [6:0]  pix_row,
	input  logic [6:0]  pix_col,
	input  logic [7:0]  up_left,
	input  logic [7:0]  up_mid,
	input  logic [7:0]  up_right,
	input  logic [7:0]  mid_left,
	input  logic [7:0]  center,
	input  logic [7:0]  mid_right,
	input  logic [7:0]  down_left,
	input  logic [7:0]  down_mid,
	input  logic [7:0]  down_right,
	output logic        done,
	output logic        foreground,
	output logic [7:0]  stale_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(SAMPLES);
	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > 8) ? $clog2(MAX_WIDTH + 1) : 8;
	localparam int HT_W  = ($clog2(MAX_HEIGHT + 1) > 8) ? $clog2(MAX_HEIGHT + 1) : 8;

	vibe_bs_pkg::state_t state_q, state_d;

	// Config registers
	logic [4:0]  min_matches_q;
	logic [7:0]  match_radius_q, update_factor_q, stale_limit_q;
	logic [7:0]  frame_width_q, frame_height_q;
	logic [31:0] rng_q;

	// Transaction registers
	logic             act_q, border_q, fg_q, nb_pend_q;
	logic [6:0]       row_q, col_q;
	logic [7:0]       win_q [9];
	logic [7:0]       stale_q;
	logic [SAMPLES-1:0][7:0] word_q;
	logic [SAMPLES-1:0] match_q;
	logic [1:0]       dr_q, dc_q;
	logic [SW-1:0]    slot_q;
	logic [SW-1:0]    k_q;
	logic [AW-1:0]    pix_q, nb_pix_q, clr_q;

	// Memory ports
	logic                   smp_we, stl_we;
	logic [AW-1:0]          mem_addr;
	logic [SAMPLES*8-1:0]   smp_wdata, smp_rdata;
	logic [7:0]             stl_wdata, stl_rdata;

	// Neighbor word with the new sample merged in
	logic [SAMPLES-1:0][7:0] nb_word;

	// Random draw
	logic [31:0] rng_next;
	logic [7:0]  draw_n, draw_val;
	logic [39:0] draw_prod;
	logic        draw_en;

	// Frame tests on the incoming pixel
	logic [WD_W-1:0] eff_w, col_x;
	logic [HT_W-1:0] eff_h, row_x;
	logic            in_outside, in_border;

	logic [7:0]       c_val;
	logic [CNT_W-1:0] match_cnt;
	logic [7:0]       stale_inc;
	logic [1:0]       draw_off;
	logic [6:0]       nb_row, nb_col;

	assign c_val     = win_q[vibe_bs_pkg::WIN_CENTER];
	assign match_cnt = CNT_W'($countones(match_q));
	assign stale_inc = stale_q + 8'd1;
	assign draw_off  = vibe_bs_pkg::off_code(draw_val[3:0]);
	assign nb_row    = row_q + 7'(dr_q) - 7'd1;
	assign nb_col    = col_q + 7'(draw_off) - 7'd1;

	always_comb begin
		nb_word         = smp_rdata;
		nb_word[slot_q] = c_val;
	end

	always_comb begin
		eff_w = (WD_W'(frame_width_q) < WD_W'(MAX_WIDTH)) ? WD_W'(frame_width_q)
			: WD_W'(MAX_WIDTH);
		eff_h = (HT_W'(frame_height_q) < HT_W'(MAX_HEIGHT)) ? HT_W'(frame_height_q)
			: HT_W'(MAX_HEIGHT);
		col_x = WD_W'(pix_col);
		row_x = HT_W'(pix_row);
		in_outside = (row_x >= eff_h) || (col_x >= eff_w);
		in_border  = (row_x == '0) || (col_x == '0) || (row_x + HT_W'(1) >= eff_h)
			|| (col_x + WD_W'(1) >= eff_w);
	end

	// Pick the range of the draw made in this state.
	always_comb begin
		case (state_q)
			vibe_bs_pkg::ST_INIT_R, vibe_bs_pkg::ST_INIT_C,
			vibe_bs_pkg::ST_BG_NR, vibe_bs_pkg::ST_BG_NC: begin
				draw_n  = vibe_bs_pkg::WINDOW_DRAW_N;
				draw_en = 1'b1;
			end
			vibe_bs_pkg::ST_BG_U1, vibe_bs_pkg::ST_BG_U2: begin
				draw_n  = update_factor_q;
				draw_en = 1'b1;
			end
			vibe_bs_pkg::ST_BG_S1, vibe_bs_pkg::ST_BG_S2,
			vibe_bs_pkg::ST_FG_P, vibe_bs_pkg::ST_FG_S: begin
				draw_n  = 8'(SAMPLES);
				draw_en = 1'b1;
			end
			default: begin
				draw_n  = 8'd0;
				draw_en = 1'b0;
			end
		endcase
	end

	assign rng_next  = vibe_bs_pkg::xorshift(rng_q);
	assign draw_prod = 40'(rng_next) * 40'(draw_n);
	assign draw_val  = draw_prod[39:32];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vibe_bs_pkg::ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = vibe_bs_pkg::ST_IDLE;
			vibe_bs_pkg::ST_IDLE: begin
				if (start) state_d = in_outside ? vibe_bs_pkg::ST_DONE : vibe_bs_pkg::ST_RD;
			end
			vibe_bs_pkg::ST_RD: state_d = vibe_bs_pkg::ST_LOAD;
			vibe_bs_pkg::ST_LOAD: begin
				if (border_q) state_d = vibe_bs_pkg::ST_DONE;
				else if (!act_q) state_d = vibe_bs_pkg::ST_INIT_R;
				else state_d = vibe_bs_pkg::ST_MATCH;
			end
			vibe_bs_pkg::ST_INIT_R: state_d = vibe_bs_pkg::ST_INIT_C;
			vibe_bs_pkg::ST_INIT_C: begin
				state_d = (k_q == SW'(SAMPLES - 1)) ? vibe_bs_pkg::ST_WR_OWN
					: vibe_bs_pkg::ST_INIT_R;
			end
			vibe_bs_pkg::ST_MATCH: state_d = vibe_bs_pkg::ST_COUNT;
			vibe_bs_pkg::ST_COUNT: begin
				if (CMP_W'(match_cnt) >= CMP_W'(min_matches_q)) state_d = vibe_bs_pkg::ST_BG_U1;
				else if (stale_inc > stale_limit_q) state_d = vibe_bs_pkg::ST_FG_P;
				else state_d = vibe_bs_pkg::ST_WR_OWN;
			end
			vibe_bs_pkg::ST_BG_U1: begin
				state_d = (draw_val == 8'd0) ? vibe_bs_pkg::ST_BG_S1 : vibe_bs_pkg::ST_BG_U2;
			end
			vibe_bs_pkg::ST_BG_S1: state_d = vibe_bs_pkg::ST_BG_U2;
			vibe_bs_pkg::ST_BG_U2: begin
				state_d = (draw_val == 8'd0) ? vibe_bs_pkg::ST_BG_NR : vibe_bs_pkg::ST_WR_OWN;
			end
			vibe_bs_pkg::ST_BG_NR: state_d = vibe_bs_pkg::ST_BG_NC;
			vibe_bs_pkg::ST_BG_NC: state_d = vibe_bs_pkg::ST_BG_S2;
			vibe_bs_pkg::ST_BG_S2: state_d = vibe_bs_pkg::ST_WR_OWN;
			vibe_bs_pkg::ST_FG_P: begin
				state_d = (draw_val == 8'd0) ? vibe_bs_pkg::ST_FG_S : vibe_bs_pkg::ST_WR_OWN;
			end
			vibe_bs_pkg::ST_FG_S: state_d = vibe_bs_pkg::ST_WR_OWN;
			vibe_bs_pkg::ST_WR_OWN: begin
				state_d = nb_pend_q ? vibe_bs_pkg::ST_NB_RD : vibe_bs_pkg::ST_DONE;
			end
			vibe_bs_pkg::ST_NB_RD: state_d = vibe_bs_pkg::ST_NB_LOAD;
			vibe_bs_pkg::ST_NB_LOAD: state_d = vibe_bs_pkg::ST_NB_WR;
			vibe_bs_pkg::ST_NB_WR: state_d = vibe_bs_pkg::ST_DONE;
			vibe_bs_pkg::ST_DONE: state_d = vibe_bs_pkg::ST_IDLE;
			default: state_d = vibe_bs_pkg::ST_IDLE;
		endcase
	end

	// Outputs and memory controls
	always_comb begin
		busy      = (state_q != vibe_bs_pkg::ST_IDLE);
		done      = (state_q == vibe_bs_pkg::ST_DONE);
		smp_we    = 1'b0;
		stl_we    = 1'b0;
		mem_addr  = pix_q;
		smp_wdata = word_q;
		stl_wdata = stale_q;
		case (state_q)
			vibe_bs_pkg::ST_CLEAR: begin
				smp_we    = 1'b1;
				stl_we    = 1'b1;
				mem_addr  = clr_q;
				smp_wdata = '0;
				stl_wdata = 8'd0;
			end
			vibe_bs_pkg::ST_WR_OWN: begin
				smp_we = 1'b1;
				stl_we = 1'b1;
			end
			vibe_bs_pkg::ST_NB_RD, vibe_bs_pkg::ST_NB_LOAD: mem_addr = nb_pix_q;
			vibe_bs_pkg::ST_NB_WR: begin
				smp_we   = 1'b1;
				mem_addr = nb_pix_q;
			end
			default: ;
		endcase
	end

	assign foreground  = fg_q;
	assign stale_count = stale_q;

	// Control state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= vibe_bs_pkg::ST_CLEAR;
			clr_q           <= '0;
			min_matches_q   <= vibe_bs_pkg::MIN_MATCHES_RST;
			match_radius_q  <= vibe_bs_pkg::MATCH_RADIUS_RST;
			update_factor_q <= vibe_bs_pkg::UPDATE_FACTOR_RST;
			stale_limit_q   <= vibe_bs_pkg::STALE_LIMIT_RST;
			frame_width_q   <= vibe_bs_pkg::FRAME_WIDTH_RST;
			frame_height_q  <= vibe_bs_pkg::FRAME_HEIGHT_RST;
			rng_q           <= vibe_bs_pkg::RANDOM_SEED_RST;
		end else begin
			state_q <= state_d;
			if (state_q == vibe_bs_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (draw_en) rng_q <= rng_next;
			if (cfg_we) begin
				case (vibe_bs_pkg::cfg_idx_t'(cfg_index))
					vibe_bs_pkg::CFG_MIN_MATCHES:   min_matches_q   <= cfg_data[4:0];
					vibe_bs_pkg::CFG_MATCH_RADIUS:  match_radius_q  <= cfg_data[7:0];
					vibe_bs_pkg::CFG_UPDATE_FACTOR: update_factor_q <= cfg_data[7:0];
					vibe_bs_pkg::CFG_STALE_LIMIT:   stale_limit_q   <= cfg_data[7:0];
					vibe_bs_pkg::CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data[7:0];
					vibe_bs_pkg::CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[7:0];
					vibe_bs_pkg::CFG_RANDOM_SEED:   rng_q <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath registers of the transaction in flight
	always_ff @(posedge clk) begin
		case (state_q)
			vibe_bs_pkg::ST_IDLE: begin
				if (start) begin
					act_q     <= action;
					row_q     <= pix_row;
					col_q     <= pix_col;
					border_q  <= in_border;
					pix_q     <= AW'(AW'(pix_row) * AW'(MAX_WIDTH)) + AW'(pix_col);
					win_q[0]  <= up_left;
					win_q[1]  <= up_mid;
					win_q[2]  <= up_right;
					win_q[3]  <= mid_left;
					win_q[4]  <= center;
					win_q[5]  <= mid_right;
					win_q[6]  <= down_left;
					win_q[7]  <= down_mid;
					win_q[8]  <= down_right;
					fg_q      <= 1'b0;
					stale_q   <= 8'd0;
					nb_pend_q <= 1'b0;
					k_q       <= '0;
				end
			end
			vibe_bs_pkg::ST_LOAD: begin
				word_q  <= smp_rdata;
				stale_q <= stl_rdata;
			end
			vibe_bs_pkg::ST_INIT_R: dr_q <= draw_off;
			vibe_bs_pkg::ST_INIT_C: begin
				word_q[k_q] <= win_q[4'(dr_q) * 4'd3 + 4'(draw_off)];
				k_q <= k_q + SW'(1);
			end
			vibe_bs_pkg::ST_MATCH: begin
				for (int i = 0; i < SAMPLES; i++) begin
					match_q[i] <= ((word_q[i] >= c_val) ? (word_q[i] - c_val)
						: (c_val - word_q[i])) < match_radius_q;
				end
			end
			vibe_bs_pkg::ST_COUNT: begin
				if (CMP_W'(match_cnt) >= CMP_W'(min_matches_q)) begin
					stale_q <= 8'd0;
				end else begin
					stale_q <= stale_inc;
					fg_q    <= 1'b1;
				end
			end
			vibe_bs_pkg::ST_BG_S1, vibe_bs_pkg::ST_FG_S: word_q[draw_val[SW-1:0]] <= c_val;
			vibe_bs_pkg::ST_BG_NR: dr_q <= draw_off;
			vibe_bs_pkg::ST_BG_NC: nb_pix_q <= AW'(AW'(nb_row) * AW'(MAX_WIDTH)) + AW'(nb_col);
			vibe_bs_pkg::ST_BG_S2: begin
				slot_q    <= draw_val[SW-1:0];
				nb_pend_q <= 1'b1;
			end
			vibe_bs_pkg::ST_NB_LOAD: word_q <= nb_word;
			default: ;
		endcase
	end

	vibe_bs_ram #(
		.WIDTH(SAMPLES * 8),
		.DEPTH(DEPTH)
	) u_sample_ram (
		.clk  (clk),
		.we   (smp_we),
		.addr (mem_addr),
		.wdata(smp_wdata),
		.rdata(smp_rdata)
	);

	vibe_bs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_stale_ram (
		.clk  (clk),
		.we   (stl_we),
		.addr (mem_addr),
		.wdata(stl_wdata),
		.rdata(stl_rdata)
	);

	`VBS_ASSERT(a_done_single, done |=> !done)
	`VBS_ASSERT(a_idle_no_write, !busy |-> !smp_we && !stl_we)
	`VBS_ASSERT(a_done_after_work, done |-> $past(busy || start))

endmodule

FILE: hw/rtl/vibe_bs_ram.sv
// Generic single-port RAM with registered read.
module vibe_bs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
